// ===== sv/pnta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnta_pkg: shared types and constants for the padded number formatter
// Widths, digit counts, ASCII helpers and the digit chain control bundle.
// ----------------------------------------------------------------------------
package pnta_pkg;

	localparam int VALUE_W    = 32;
	localparam int PAD_W      = 6;
	localparam int CHAR_W     = 8;
	localparam int NIBBLE_W   = 4;
	localparam int MAX_PAD    = 32;
	localparam int DEC_DIGITS = 10;
	localparam int HEX_LEN    = 8;
	localparam int COUNT_W    = $clog2(MAX_PAD + 1);
	localparam int BIT_CNT_W  = $clog2(VALUE_W);
	localparam int DIGIT_IDX_W = $clog2(DEC_DIGITS);

	localparam logic OP_DEC = 1'b0;
	localparam logic OP_HEX = 1'b1;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;

	typedef logic [DEC_DIGITS-1:0][NIBBLE_W-1:0] pnta_digits_t;

	typedef struct packed {
		logic load;
		logic hex;
		logic shift;
	} pnta_chain_ctrl_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [NIBBLE_W-1:0] d);
		logic [CHAR_W-1:0] c;
		case (d)
			4'h0: c = 8'h30;
			4'h1: c = 8'h31;
			4'h2: c = 8'h32;
			4'h3: c = 8'h33;
			4'h4: c = 8'h34;
			4'h5: c = 8'h35;
			4'h6: c = 8'h36;
			4'h7: c = 8'h37;
			4'h8: c = 8'h38;
			4'h9: c = 8'h39;
			4'ha: c = 8'h61;
			4'hb: c = 8'h62;
			4'hc: c = 8'h63;
			4'hd: c = 8'h64;
			4'he: c = 8'h65;
			default: c = 8'h66;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== sv/pnta_digit_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnta_digit_cell: one digit cell of the conversion chain
// Holds one digit; on shift, adds three when five or above and moves one bit
// up, handing its top bit to the next cell.
// ----------------------------------------------------------------------------
module pnta_digit_cell (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire  pnta_pkg::pnta_chain_ctrl_t   ctrl,
	input  wire                                carry_in,
	input  wire  [pnta_pkg::NIBBLE_W-1:0]      hex_nibble,
	output logic [pnta_pkg::NIBBLE_W-1:0]      digit,
	output logic                               carry_out
);

	logic [pnta_pkg::NIBBLE_W-1:0] digit_q;
	logic [pnta_pkg::NIBBLE_W-1:0] adj;

	always_comb begin
		adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctrl.load) begin
			digit_q <= ctrl.hex ? hex_nibble : '0;
		end else if (ctrl.shift) begin
			digit_q <= {adj[pnta_pkg::NIBBLE_W-2:0], carry_in};
		end
	end

	assign digit     = digit_q;
	assign carry_out = adj[pnta_pkg::NIBBLE_W-1];

endmodule
`default_nettype wire

// ===== sv/pnta_digit_chain.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pnta_digit_chain: row of digit cells
// Shifts the value in one bit a cycle, least significant cell first, or
// loads hex nibbles straight into the low cells.
// ----------------------------------------------------------------------------
module pnta_digit_chain (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire  pnta_pkg::pnta_chain_ctrl_t  ctrl,
	input  wire                               serial_bit,
	input  wire  [pnta_pkg::VALUE_W-1:0]      load_value,
	output pnta_pkg::pnta_digits_t            digits
);

	logic [pnta_pkg::DEC_DIGITS:0] carry;

	assign carry[0] = serial_bit;

	for (genvar i = 0; i < pnta_pkg::DEC_DIGITS; i++) begin : g_cell
		logic [pnta_pkg::NIBBLE_W-1:0] nib;
		if (i < pnta_pkg::HEX_LEN) begin : g_hex
			assign nib = load_value[i*pnta_pkg::NIBBLE_W +: pnta_pkg::NIBBLE_W];
		end else begin : g_nohex
			assign nib = '0;
		end
		pnta_digit_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.carry_in   (carry[i]),
			.hex_nibble (nib),
			.digit      (digits[i]),
			.carry_out  (carry[i+1])
		);
	end

endmodule
`default_nettype wire

// ===== sv/padded_number_to_ascii.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// padded_number_to_ascii: formats a 32-bit number as ASCII characters
// Input item: operation (0 decimal, 1 hex), value, pad_width. Output items:
// one character each, most significant first, last set on the final one.
// Decimal drops leading zeros ("0" for zero); hex is eight lower-case digits;
// '0' fill comes first up to pad_width, which saturates at 32.
// Decimal shifts every value bit in through the ten digit cells, adjusting
// as it goes; hex loads the cells as the item is taken. A sizing state then
// counts the digits, and the characters leave one per cycle unless out_ready
// stalls them. The character count runs from 1 to 32. in_ready is high only
// while idle. The output register decouples the two sides: the final
// character may wait for out_ready while the next item is taken in and
// converted. A stall on out_ready holds the character and pauses emission.
// Reset empties the output and returns to idle.
// ----------------------------------------------------------------------------
module padded_number_to_ascii (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire                                operation,
	input  wire  [pnta_pkg::VALUE_W-1:0]       value,
	input  wire  [pnta_pkg::PAD_W-1:0]         pad_width,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [pnta_pkg::CHAR_W-1:0]        character,
	output logic                               last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIZE,
		ST_EMIT
	} state_t;

	state_t                             state_q;
	logic [pnta_pkg::VALUE_W-1:0]       value_q;
	logic [pnta_pkg::COUNT_W-1:0]       pad_q;
	logic                               op_q;
	logic [pnta_pkg::BIT_CNT_W-1:0]     bit_cnt_q;
	logic [pnta_pkg::COUNT_W-1:0]       ndig_q;
	logic [pnta_pkg::COUNT_W-1:0]       rem_q;
	logic                               out_valid_q;
	logic [pnta_pkg::CHAR_W-1:0]        character_q;
	logic                               last_q;

	pnta_pkg::pnta_chain_ctrl_t         ctrl;
	pnta_pkg::pnta_digits_t             digits;
	logic                               accept;
	logic                               out_free;
	logic                               emit;
	logic [pnta_pkg::COUNT_W-1:0]       pad_sat;
	logic [pnta_pkg::COUNT_W-1:0]       ndig_dec;
	logic [pnta_pkg::COUNT_W-1:0]       ndig;
	logic [pnta_pkg::DIGIT_IDX_W-1:0]   digit_idx;
	logic [pnta_pkg::CHAR_W-1:0]        next_char;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign emit     = (state_q == ST_EMIT) && out_free;

	assign pad_sat = (pad_width > pnta_pkg::PAD_W'(pnta_pkg::MAX_PAD))
		? pnta_pkg::COUNT_W'(pnta_pkg::MAX_PAD)
		: pnta_pkg::COUNT_W'(pad_width);

	always_comb begin
		ctrl.load  = accept;
		ctrl.hex   = (operation == pnta_pkg::OP_HEX);
		ctrl.shift = (state_q == ST_CONV);
	end

	pnta_digit_chain u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.serial_bit (value_q[pnta_pkg::VALUE_W-1]),
		.load_value (value),
		.digits     (digits)
	);

	always_comb begin
		ndig_dec = pnta_pkg::COUNT_W'(1);
		for (int i = 1; i < pnta_pkg::DEC_DIGITS; i++) begin
			if (digits[i] != '0) begin
				ndig_dec = pnta_pkg::COUNT_W'(i + 1);
			end
		end
		ndig = (op_q == pnta_pkg::OP_HEX) ? pnta_pkg::COUNT_W'(pnta_pkg::HEX_LEN)
		                                   : ndig_dec;
	end

	always_comb begin
		digit_idx = pnta_pkg::DIGIT_IDX_W'(rem_q - pnta_pkg::COUNT_W'(1));
		if (rem_q > ndig_q || digit_idx >= pnta_pkg::DIGIT_IDX_W'(pnta_pkg::DEC_DIGITS)) begin
			next_char = pnta_pkg::CHAR_ZERO;
		end else begin
			next_char = pnta_pkg::digit_char(digits[digit_idx]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			value_q     <= '0;
			pad_q       <= '0;
			op_q        <= pnta_pkg::OP_DEC;
			bit_cnt_q   <= '0;
			ndig_q      <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
			character_q <= '0;
			last_q      <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						value_q   <= value;
						pad_q     <= pad_sat;
						op_q      <= operation;
						bit_cnt_q <= '0;
						state_q   <= (operation == pnta_pkg::OP_HEX) ? ST_SIZE : ST_CONV;
					end
				end
				ST_CONV: begin
					value_q   <= {value_q[pnta_pkg::VALUE_W-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == pnta_pkg::BIT_CNT_W'(pnta_pkg::VALUE_W - 1)) begin
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE: begin
					ndig_q  <= ndig;
					rem_q   <= (pad_q > ndig) ? pad_q : ndig;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit) begin
						character_q <= next_char;
						last_q      <= (rem_q == pnta_pkg::COUNT_W'(1));
						rem_q       <= rem_q - 1'b1;
						if (rem_q == pnta_pkg::COUNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign character = character_q;
	assign last      = last_q;

endmodule
`default_nettype wire

// ===== tb/sv/padded_number_to_ascii_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padded_number_to_ascii_tb: self-checking bench for the padded number formatter
// Numbers queued by the stimulus block are offered by a falling-edge driver.
// Each accepted number is expanded here into its expected character stream.
// A rising-edge monitor checks every character and last flag in order.
// Runs one directed set, then random numbers under four sender and receiver
// idling patterns, with one long receiver hold-off to back up the input.
// ----------------------------------------------------------------------------
module padded_number_to_ascii_tb;

	localparam int LIMIT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 300;
	localparam logic [pnta_pkg::CHAR_W-1:0] CHAR_LOWER_A = 8'h61;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic                         op;
		logic [pnta_pkg::VALUE_W-1:0] number;
		logic [pnta_pkg::PAD_W-1:0]   pad;
	} number_item_t;

	typedef struct packed {
		logic [pnta_pkg::CHAR_W-1:0] ch;
		logic                        fin;
	} ascii_char_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = pnta_pkg::OP_DEC;
	logic [pnta_pkg::VALUE_W-1:0] value = '0;
	logic [pnta_pkg::PAD_W-1:0] pad_width = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [pnta_pkg::CHAR_W-1:0] character;
	logic last;

	number_item_t pending_numbers[$];
	ascii_char_t expected_chars[$];
	idle_mode_t idle_mode = IDLE_NONE;
	logic in_taken = 1'b0;
	logic hold_request = 1'b0;
	logic hold_served = 1'b0;
	int hold_left = 0;
	int error_count = 0;
	int cycle_count = 0;

	padded_number_to_ascii DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.value(value),
		.pad_width(pad_width),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.character(character),
		.last(last)
	);

	always #1 clk = ~clk;

	// expand one number into the characters it should produce
	function automatic void predict_chars(input logic op,
			input logic [pnta_pkg::VALUE_W-1:0] number,
			input logic [pnta_pkg::PAD_W-1:0] pad);
		logic [pnta_pkg::CHAR_W-1:0] digs [0:pnta_pkg::DEC_DIGITS-1];
		logic [pnta_pkg::CHAR_W-1:0] rev [0:pnta_pkg::DEC_DIGITS-1];
		logic [pnta_pkg::VALUE_W-1:0] rem;
		logic [pnta_pkg::NIBBLE_W-1:0] nib;
		int nd;
		int eff;
		int fill;
		int total;
		ascii_char_t c;
		nd = 0;
		if (op == pnta_pkg::OP_HEX) begin
			for (int i = 0; i < pnta_pkg::HEX_LEN; i++) begin
				nib = number[pnta_pkg::VALUE_W-1-pnta_pkg::NIBBLE_W*i -: pnta_pkg::NIBBLE_W];
				digs[i] = (nib < pnta_pkg::NIBBLE_W'(10))
					? pnta_pkg::CHAR_ZERO + pnta_pkg::CHAR_W'(nib)
					: CHAR_LOWER_A + pnta_pkg::CHAR_W'(nib) - pnta_pkg::CHAR_W'(10);
			end
			nd = pnta_pkg::HEX_LEN;
		end else begin
			rem = number;
			do begin
				rev[nd] = pnta_pkg::CHAR_ZERO + pnta_pkg::CHAR_W'(rem % 10);
				nd++;
				rem = rem / 10;
			end while (rem != 0);
			for (int i = 0; i < nd; i++)
				digs[i] = rev[nd-1-i];
		end
		eff = (pad > pnta_pkg::MAX_PAD) ? pnta_pkg::MAX_PAD : int'(pad);
		fill = (eff > nd) ? eff - nd : 0;
		total = fill + nd;
		for (int k = 0; k < total; k++) begin
			c.ch = (k < fill) ? pnta_pkg::CHAR_ZERO : digs[k-fill];
			c.fin = (k == total - 1);
			expected_chars.push_back(c);
		end
	endfunction

	function automatic logic sender_idle();
		case (idle_mode)
			IDLE_SENDER: return $urandom_range(99) < 74;
			IDLE_BOTH:   return $urandom_range(99) < 30;
			default:     return 1'b0;
		endcase
	endfunction

	function automatic logic receiver_stall();
		case (idle_mode)
			IDLE_RECEIVER: return $urandom_range(99) < 74;
			IDLE_BOTH:     return $urandom_range(99) < 30;
			default:       return 1'b0;
		endcase
	endfunction

	function automatic logic [pnta_pkg::VALUE_W-1:0] random_number();
		logic [pnta_pkg::VALUE_W-1:0] p;
		p = 1;
		case ($urandom_range(4))
			0: return $urandom;
			1: return $urandom_range(0, 20);
			2: begin
				repeat ($urandom_range(0, 9)) p = p * 10;
				return p + $urandom_range(0, 2) - 1;
			end
			3: return $urandom >> $urandom_range(0, 31);
			default: return '1 - $urandom_range(0, 3);
		endcase
	endfunction

	function automatic logic [pnta_pkg::PAD_W-1:0] random_pad();
		case ($urandom_range(9))
			7, 8: return pnta_pkg::PAD_W'($urandom_range(0, 33));
			9: return pnta_pkg::PAD_W'($urandom_range(0, 63));
			default: return pnta_pkg::PAD_W'($urandom_range(0, 12));
		endcase
	endfunction

	task automatic push_number(input logic op, input logic [pnta_pkg::VALUE_W-1:0] number,
			input logic [pnta_pkg::PAD_W-1:0] pad);
		number_item_t it;
		it.op = op;
		it.number = number;
		it.pad = pad;
		pending_numbers.push_back(it);
	endtask

	task automatic push_random(input int count);
		repeat (count) push_number(1'($urandom_range(1)), random_number(), random_pad());
	endtask

	task automatic wait_drained();
		while (pending_numbers.size() != 0 || in_valid || expected_chars.size() != 0)
			@(posedge clk);
	endtask

	// offer the next number once the current one is taken
	always @(negedge clk) begin : driver
		number_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_numbers.size() != 0 && !sender_idle()) begin
				it = pending_numbers.pop_front();
				in_valid <= 1'b1;
				operation <= it.op;
				value <= it.number;
				pad_width <= it.pad;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// hold off for a long stretch once when asked, otherwise stall at random
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_request && !hold_served) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_served <= 1'b1;
		end else begin
			out_ready <= !receiver_stall();
		end
	end

	always @(posedge clk) begin : monitor
		ascii_char_t want;
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			predict_chars(operation, value, pad_width);
		if (arst_n && out_valid && out_ready) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected item character %h last %b", $time, character, last);
				error_count++;
			end else begin
				want = expected_chars.pop_front();
				if (character !== want.ch) begin
					$display("%0t: character expected %h actual %h", $time, want.ch, character);
					error_count++;
				end
				if (last !== want.fin) begin
					$display("%0t: last expected %b actual %b", $time, want.fin, last);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("padded_number_to_ascii_tb NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// zero, extremes, digit-count boundaries and pad saturation
		push_number(pnta_pkg::OP_DEC, 32'd0, 6'd0);
		push_number(pnta_pkg::OP_DEC, 32'd0, 6'd32);
		push_number(pnta_pkg::OP_DEC, 32'd0, 6'd63);
		push_number(pnta_pkg::OP_DEC, 32'd9, 6'd1);
		push_number(pnta_pkg::OP_DEC, 32'd10, 6'd2);
		push_number(pnta_pkg::OP_DEC, 32'd999999999, 6'd9);
		push_number(pnta_pkg::OP_DEC, 32'd1000000000, 6'd0);
		push_number(pnta_pkg::OP_DEC, 32'hffffffff, 6'd10);
		push_number(pnta_pkg::OP_DEC, 32'hffffffff, 6'd11);
		push_number(pnta_pkg::OP_DEC, 32'h80000000, 6'd33);
		push_number(pnta_pkg::OP_DEC, 32'd12345, 6'd40);
		push_number(pnta_pkg::OP_DEC, 32'd7, 6'd21);
		push_number(pnta_pkg::OP_HEX, 32'h0, 6'd0);
		push_number(pnta_pkg::OP_HEX, 32'hdeadbeef, 6'd8);
		push_number(pnta_pkg::OP_HEX, 32'h0123abcd, 6'd9);
		push_number(pnta_pkg::OP_HEX, 32'hffffffff, 6'd32);
		push_number(pnta_pkg::OP_HEX, 32'h89abcdef, 6'd63);
		push_number(pnta_pkg::OP_HEX, 32'h76543210, 6'd33);
		push_number(pnta_pkg::OP_HEX, 32'h00000001, 6'd16);
		push_number(pnta_pkg::OP_DEC, 32'h55555555, 6'd42);
		push_number(pnta_pkg::OP_HEX, 32'haaaaaaaa, 6'd21);
		wait_drained();

		// back up the input behind a long receiver hold-off
		push_random(120);
		hold_request = 1'b1;
		wait_drained();

		idle_mode = IDLE_SENDER;
		push_random(120);
		wait_drained();

		idle_mode = IDLE_RECEIVER;
		push_random(120);
		wait_drained();

		idle_mode = IDLE_BOTH;
		push_random(120);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("padded_number_to_ascii_tb OK");
		else
			$display("padded_number_to_ascii_tb NOT OK");
		$finish;
	end

endmodule
